// File: sv/fir_lowpass_with_integrator_defines.svh
// Assertion macros for the low-pass filter and integrator block.
`ifndef FIR_LOWPASS_WITH_INTEGRATOR_DEFINES_SVH
`define FIR_LOWPASS_WITH_INTEGRATOR_DEFINES_SVH

// Same-cycle implication, sampled on clk_i, off while in reset.
`define FLI_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("fli assertion failed");

// Next-cycle implication, sampled on clk_i, off while in reset.
`define FLI_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("fli assertion failed");

`endif

// File: sv/fli_pkg.sv
// Package: constants, coefficient table and control structs for the filter.
`timescale 1ns / 1ps
package fli_pkg;

  localparam int ACC_W     = 64;
  localparam int COEF_W    = 32;
  localparam int POS_W     = 32;
  localparam int TABLE_LEN = 33;

  localparam logic signed [COEF_W-1:0] Q31_TAPS [TABLE_LEN] = '{
    32'sd2791729,   32'sd3865471,   32'sd6227703,   32'sd10093173,  32'sd15891379,
    32'sd23622320,  32'sd33715492,  32'sd45956152,  32'sd59700044,  32'sd74517680,
    32'sd89764816,  32'sd104582456, 32'sd118111600, 32'sd129708016, 32'sd138512688,
    32'sd144096160, 32'sd146028896, 32'sd144096160, 32'sd138512688, 32'sd129708016,
    32'sd118111600, 32'sd104582456, 32'sd89764816,  32'sd74517680,  32'sd59700044,
    32'sd45956152,  32'sd33715492,  32'sd23622320,  32'sd15891379,  32'sd10093173,
    32'sd6227703,   32'sd3865471,   32'sd2791729
  };

  typedef struct packed {
    logic push;
    logic rotate;
  } dl_ctrl_t;

  typedef struct packed {
    logic clear;
    logic mul_en;
  } mac_ctrl_t;

  // Coefficient for tap idx, rounded half up to frac fractional bits.
  function automatic logic signed [COEF_W-1:0] coef_at(input int unsigned idx,
                                                       input int unsigned frac);
    logic signed [COEF_W:0] c;
    int unsigned            drop;
    drop = 31 - frac;
    c    = '0;
    if (idx < TABLE_LEN) begin
      c = {Q31_TAPS[idx][COEF_W-1], Q31_TAPS[idx]};
      if (drop > 0) begin
        c = (c + (33'sd1 <<< (drop - 1))) >>> drop;
      end
    end
    return c[COEF_W-1:0];
  endfunction

endpackage

// File: sv/fli_ifs.sv
// Valid/ready channel interfaces for sample input and filtered output words.
`timescale 1ns / 1ps
interface fli_in_if #(
  parameter int SAMPLE_WIDTH = 16
);
  logic                           valid;
  logic                           ready;
  logic signed [SAMPLE_WIDTH-1:0] sample;

  modport source (output valid, output sample, input ready);
  modport sink   (input valid, input sample, output ready);
endinterface

interface fli_out_if #(
  parameter int SAMPLE_WIDTH = 16
);
  logic                           valid;
  logic                           ready;
  logic signed [SAMPLE_WIDTH-1:0] filtered;
  logic signed [31:0]             position;

  modport source (output valid, output filtered, output position, input ready);
  modport sink   (input valid, input filtered, input position, output ready);
endinterface

// File: sv/fli_delay.sv
// Rotating sample delay line: push a new sample, then rotate to present taps at entry 0.
`timescale 1ns / 1ps
module fli_delay
  import fli_pkg::*;
#(
  parameter int TAPS         = 33,
  parameter int SAMPLE_WIDTH = 16
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  dl_ctrl_t                       ctrl_i,
  input  logic signed [SAMPLE_WIDTH-1:0] sample_i,
  output logic signed [SAMPLE_WIDTH-1:0] tap_o
);

  logic signed [SAMPLE_WIDTH-1:0] line_q [TAPS];
  logic signed [SAMPLE_WIDTH-1:0] line_d [TAPS];

  always_comb begin
    for (int i = 0; i < TAPS; i++) begin
      line_d[i] = line_q[i];
    end
    if (ctrl_i.push) begin
      line_d[0] = sample_i;
      for (int i = 1; i < TAPS; i++) begin
        line_d[i] = line_q[i-1];
      end
    end else if (ctrl_i.rotate) begin
      for (int i = 0; i < TAPS; i++) begin
        line_d[i] = line_q[(i + 1) % TAPS];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < TAPS; i++) begin
        line_q[i] <= '0;
      end
    end else begin
      for (int i = 0; i < TAPS; i++) begin
        line_q[i] <= line_d[i];
      end
    end
  end

  assign tap_o = line_q[0];

endmodule

// File: sv/fli_mac.sv
// Shared multiply-accumulate unit: registered product into a 64-bit accumulator.
`timescale 1ns / 1ps
module fli_mac
  import fli_pkg::*;
#(
  parameter int SAMPLE_WIDTH = 16
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  mac_ctrl_t                      ctrl_i,
  input  logic signed [SAMPLE_WIDTH-1:0] tap_i,
  input  logic signed [COEF_W-1:0]       coef_i,
  output logic                           busy_o,
  output logic signed [ACC_W-1:0]        acc_o
);

  localparam int PW = SAMPLE_WIDTH + COEF_W;

  logic signed [PW-1:0]    prod_q;
  logic                    prod_vld_q;
  logic signed [ACC_W-1:0] acc_q;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.mul_en) begin
      prod_q <= tap_i * coef_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prod_vld_q <= 1'b0;
      acc_q      <= '0;
    end else if (ctrl_i.clear) begin
      prod_vld_q <= 1'b0;
      acc_q      <= '0;
    end else begin
      prod_vld_q <= ctrl_i.mul_en;
      if (prod_vld_q) begin
        acc_q <= acc_q + {{(ACC_W-PW){prod_q[PW-1]}}, prod_q};
      end
    end
  end

  assign busy_o = prod_vld_q;
  assign acc_o  = acc_q;

endmodule

// File: sv/fir_lowpass_with_integrator.sv
// Low-pass FIR filter with saturating integrator, built round one shared MAC.
//
// Input channel in_i carries one signed sample per word; output channel out_o
// returns one word per input: the filtered sample and the running position.
// Each word runs through a sequencer that feeds the TAPS delay-line entries,
// one per cycle, through a single multiplier and 64-bit accumulator, then
// shifts, saturates and integrates. in_i.ready is high only while the
// sequencer is idle, so a new word is taken only once the previous word
// has left the sequencer.
// The result sits in an output register; the next word is accepted and
// processed while it waits. If out_o.ready stays low, the sequencer holds
// the finished word in its last step until the register frees, and the
// input then stays blocked.
// Reset (rst_ni low, asynchronous) clears the delay line, the integrator
// and the output valid flag.
`timescale 1ns / 1ps
`include "fir_lowpass_with_integrator_defines.svh"
module fir_lowpass_with_integrator
  import fli_pkg::*;
#(
  parameter int TAPS           = 33,
  parameter int SAMPLE_WIDTH   = 16,
  parameter int COEF_FRAC_BITS = 31
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  fli_in_if.sink         in_i,
  fli_out_if.source      out_o
);

  localparam int CNT_W = (TAPS > 1) ? $clog2(TAPS) : 1;
  localparam logic [CNT_W-1:0] LAST = CNT_W'(TAPS - 1);
  localparam logic signed [ACC_W-1:0] SMAX = (64'sd1 <<< (SAMPLE_WIDTH - 1)) - 64'sd1;
  localparam logic signed [ACC_W-1:0] SMIN = -SMAX - 64'sd1;

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_MAC   = 5'b00010,
    ST_DRAIN = 5'b00100,
    ST_SAT   = 5'b01000,
    ST_INTEG = 5'b10000
  } state_e;

  state_e state_q, state_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;

  dl_ctrl_t  dl_ctrl;
  mac_ctrl_t mac_ctrl;

  logic signed [SAMPLE_WIDTH-1:0] tap;
  logic signed [COEF_W-1:0]       coef;
  logic signed [ACC_W-1:0]        acc;
  logic signed [ACC_W-1:0]        acc_sh;
  logic                           mac_busy;

  logic signed [SAMPLE_WIDTH-1:0] y_q, y_d;
  logic signed [POS_W-1:0]        pos_q, pos_d;
  logic signed [POS_W:0]          pos_sum;

  logic                           out_vld_q;
  logic signed [SAMPLE_WIDTH-1:0] out_filt_q;
  logic signed [POS_W-1:0]        out_pos_q;

  logic in_acc;
  logic load;

  assign in_i.ready = (state_q == ST_IDLE);
  assign in_acc     = in_i.valid && in_i.ready;
  assign load       = (state_q == ST_INTEG) && (!out_vld_q || out_o.ready);

  assign coef = coef_at(int'(cnt_q), COEF_FRAC_BITS);

  fli_delay #(
    .TAPS         (TAPS),
    .SAMPLE_WIDTH (SAMPLE_WIDTH)
  ) u_delay (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctrl_i   (dl_ctrl),
    .sample_i (in_i.sample),
    .tap_o    (tap)
  );

  fli_mac #(
    .SAMPLE_WIDTH (SAMPLE_WIDTH)
  ) u_mac (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (mac_ctrl),
    .tap_i  (tap),
    .coef_i (coef),
    .busy_o (mac_busy),
    .acc_o  (acc)
  );

  always_comb begin
    state_d         = state_q;
    cnt_d           = cnt_q;
    dl_ctrl.push    = 1'b0;
    dl_ctrl.rotate  = 1'b0;
    mac_ctrl.clear  = 1'b0;
    mac_ctrl.mul_en = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          dl_ctrl.push   = 1'b1;
          mac_ctrl.clear = 1'b1;
          cnt_d          = '0;
          state_d        = ST_MAC;
        end
      end
      ST_MAC: begin
        mac_ctrl.mul_en = 1'b1;
        dl_ctrl.rotate  = 1'b1;
        if (cnt_q == LAST) begin
          state_d = ST_DRAIN;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      ST_DRAIN: state_d = ST_SAT;
      ST_SAT:   state_d = ST_INTEG;
      ST_INTEG: begin
        if (load) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // floor shift, then clamp to the sample range
  assign acc_sh = acc >>> COEF_FRAC_BITS;

  always_comb begin
    if (acc_sh > SMAX) begin
      y_d = SMAX[SAMPLE_WIDTH-1:0];
    end else if (acc_sh < SMIN) begin
      y_d = SMIN[SAMPLE_WIDTH-1:0];
    end else begin
      y_d = acc_sh[SAMPLE_WIDTH-1:0];
    end
  end

  assign pos_sum = {pos_q[POS_W-1], pos_q} +
                   {{(POS_W+1-SAMPLE_WIDTH){y_q[SAMPLE_WIDTH-1]}}, y_q};

  always_comb begin
    if (pos_sum[POS_W] != pos_sum[POS_W-1]) begin
      pos_d = pos_sum[POS_W] ? {1'b1, {(POS_W-1){1'b0}}} : {1'b0, {(POS_W-1){1'b1}}};
    end else begin
      pos_d = pos_sum[POS_W-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_SAT) begin
      y_q <= y_d;
    end
    if (load) begin
      out_filt_q <= y_q;
      out_pos_q  <= pos_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      cnt_q     <= '0;
      pos_q     <= '0;
      out_vld_q <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      if (load) begin
        pos_q     <= pos_d;
        out_vld_q <= 1'b1;
      end else if (out_o.ready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  assign out_o.valid    = out_vld_q;
  assign out_o.filtered = out_filt_q;
  assign out_o.position = out_pos_q;

  `FLI_ASSERT_NXT(a_start_mac, in_acc, (state_q == ST_MAC) && (cnt_q == '0))
  `FLI_ASSERT_IMP(a_cnt_range, state_q == ST_MAC, cnt_q <= LAST)
  `FLI_ASSERT_IMP(a_mac_drained, state_q == ST_SAT, !mac_busy)
  `FLI_ASSERT_NXT(a_hold_result, (state_q == ST_INTEG) && out_vld_q && !out_o.ready,
                  state_q == ST_INTEG)
  `FLI_ASSERT_NXT(a_pos_rises, load && !y_q[SAMPLE_WIDTH-1],
                  $signed(pos_q) >= $signed($past(pos_q)))

endmodule
